// ===== rtl/bgsp_pkg.sv =====
// Shared constants, types and a helper function of the beat gated sample player.
package bgsp_pkg;

  localparam int MEM_DEPTH    = 16384;
  localparam int SAMPLE_WIDTH = 16;
  localparam int ADDR_W       = $clog2(MEM_DEPTH);

  localparam int IN_ADDR_W  = 14;
  localparam int AUDIO_W    = 16;
  localparam int POS_W      = 18;
  localparam int CYC_W      = POS_W + 1;
  localparam int STEP_W     = 32;
  localparam int CNT_W      = 15;
  localparam int GAIN_W     = 16;
  localparam int FRAC_W     = 16;
  localparam int IDX_W      = POS_W + STEP_W;
  localparam int LIM_CNT_W  = 17;
  localparam int LIM_W      = LIM_CNT_W + FRAC_W;
  localparam int ENV_W      = 17;
  localparam int ENV_PROD_W = LIM_W + GAIN_W;

  localparam int DIV_W     = CYC_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int VW = SAMPLE_WIDTH + 19;
  localparam int PW = VW + ENV_W + 1;
  localparam int PE = PW + 1;
  localparam int SH = FRAC_W + SAMPLE_WIDTH;

  localparam logic signed [PE-1:0] SAT_HI = PE'(32767);
  localparam logic signed [PE-1:0] SAT_LO = -(PE'(32768));

  localparam logic [CYC_W-1:0] CYC_ZERO_LEN = CYC_W'(262144);
  localparam logic [ENV_W-1:0] ENV_ONE      = ENV_W'(65536);

  typedef logic [1:0] bgsp_mode_t;
  localparam bgsp_mode_t MODE_LOAD   = 2'd0;
  localparam bgsp_mode_t MODE_RENDER = 2'd1;
  localparam bgsp_mode_t MODE_SETPOS = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_START   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LENGTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_LENGTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_GAIN    = 3'd6;

  typedef struct packed {
    logic load_wr;
    logic set_pos;
    logic start_send;
    logic start_pos;
    logic store_send;
    logic store_pos;
    logic render_chk;
    logic mul;
    logic idx;
    logic rd1;
    logic interp;
    logic prod;
    logic out_load;
  } bgsp_cmd_t;

  typedef struct packed {
    logic send_ok;
    logic bp_ge_cyc;
    logic mod_done;
    logic out_free;
  } bgsp_stat_t;

  localparam int SCL_L = (SAMPLE_WIDTH >= 16) ? SAMPLE_WIDTH - 16 : 0;
  localparam int SCL_R = (SAMPLE_WIDTH >= 16) ? 0 : 16 - SAMPLE_WIDTH;

  // Q1.15 word to store width: left shift, or floor right shift
  function automatic logic signed [SAMPLE_WIDTH-1:0] scale_in(input logic signed [15:0] v);
    logic signed [SAMPLE_WIDTH+15:0] w;
    w = (SAMPLE_WIDTH+16)'(v);
    w = (w <<< SCL_L) >>> SCL_R;
    return w[SAMPLE_WIDTH-1:0];
  endfunction

endpackage

// ===== rtl/bgsp_ram.sv =====
// Generic single-port RAM with registered read.
module bgsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bgsp_modu.sv =====
// Restoring modulo unit, one remainder bit per cycle.
module bgsp_modu import bgsp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [DIV_W-1:0] rem,
  output logic             done
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     dvd_r, dvd_nxt;
  logic [DIV_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       trial_sub;

  always_comb begin
    trial     = {rem_r, dvd_r[DIV_W-1]};
    trial_sub = trial - {1'b0, dvs_r};
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    dvs_nxt   = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, dvs_r}) ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rem  = rem_r;
  assign done = done_r;

endmodule

// ===== rtl/bgsp_dp.sv =====
// Datapath: configuration, beat position, window test, index, envelope and interpolation.
module bgsp_dp import bgsp_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_wdata,
  input  logic [IN_ADDR_W-1:0]           in_address,
  input  logic signed [15:0]             in_sample_value,
  input  logic [POS_W-1:0]               in_position,
  input  bgsp_cmd_t                      cmd,
  output bgsp_stat_t                     stat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [AUDIO_W-1:0]      out_audio,
  output logic                           out_gate
);

  // configuration
  logic [CNT_W-1:0]  sample_count_r;
  logic [POS_W-1:0]  cycle_length_r;
  logic [POS_W-1:0]  slot_start_r;
  logic [POS_W-1:0]  slot_length_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  fade_length_r;
  logic [GAIN_W-1:0] fade_gain_r;

  logic [POS_W-1:0] bp_r;
  logic             send_ok_r;
  logic [CYC_W-1:0] send_mod_r;

  logic [POS_W-1:0]           t_r;
  logic                       gate_r;
  logic                       silent_r;
  logic [IDX_W-1:0]           idx_r;
  logic                       over_r;
  logic [ADDR_W-1:0]          i1_r;
  logic [FRAC_W-1:0]          frac_r;
  logic [LIM_W-1:0]           env_a_r;
  logic                       env_full_r;
  logic [ENV_PROD_W-1:0]      env_prod_r;
  logic signed [SAMPLE_WIDTH-1:0] s0_r;
  logic signed [VW-1:0]       v_r;
  logic [ENV_W-1:0]           env_r;
  logic signed [PW-1:0]       p_r;

  logic                       out_valid_r;
  logic signed [AUDIO_W-1:0]  out_audio_r;
  logic                       out_gate_r;

  // window and position
  logic [CYC_W-1:0]  cyc;
  logic [CYC_W-1:0]  send;
  logic [CYC_W-1:0]  pos;
  logic [CYC_W-1:0]  pos_inc;
  logic              inwin;
  logic signed [CYC_W+1:0] t1;
  logic signed [CYC_W+1:0] t2;

  // index and envelope
  logic [LIM_CNT_W-1:0] cnt;
  logic [LIM_CNT_W-1:0] i0_ext;
  logic [LIM_CNT_W-1:0] i1_ext;
  logic [LIM_CNT_W-1:0] cnt_m1;
  logic [LIM_W-1:0]     lim;
  logic [LIM_W-1:0]     fl;
  logic [LIM_W-1:0]     idx_s;
  logic [LIM_W:0]       near_sum;
  logic                 before_fade_end;
  logic [ENV_PROD_W-FRAC_W-1:0] env_sh;

  // interpolation and output
  logic signed [SAMPLE_WIDTH-1:0] s1;
  logic signed [SAMPLE_WIDTH:0]   diff;
  logic signed [VW-1:0]           dprod;
  logic signed [PE-1:0]           rnd;
  logic signed [PE-1:0]           r_sh;
  logic signed [AUDIO_W-1:0]      audio_sat;

  // memory
  logic [16:0]               ld_addr_ext;
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_addr;
  logic [SAMPLE_WIDTH-1:0]   ram_rdata;

  logic [DIV_W-1:0] mod_rem;
  logic             mod_done;
  logic             mod_start;
  logic [DIV_W-1:0] mod_dvd;

  always_comb begin
    cyc     = (cycle_length_r == '0) ? CYC_ZERO_LEN : CYC_W'(cycle_length_r);
    send    = CYC_W'(slot_start_r) + CYC_W'(slot_length_r);
    pos     = CYC_W'(bp_r);
    pos_inc = pos + 1'b1;
    if (send <= cyc) begin
      inwin = (pos >= CYC_W'(slot_start_r)) && (pos < send);
    end else begin
      // window wraps past the cycle end
      inwin = (pos >= CYC_W'(slot_start_r)) || (pos < send_mod_r);
    end
    t1 = $signed({2'b00, pos}) - $signed({2'b00, CYC_W'(slot_start_r)});
    t2 = (t1 < 0) ? t1 + $signed({2'b00, cyc}) : t1;
  end

  always_comb begin
    cnt = (LIM_CNT_W'(sample_count_r) < LIM_CNT_W'(MEM_DEPTH)) ?
          LIM_CNT_W'(sample_count_r) : LIM_CNT_W'(MEM_DEPTH);
    lim    = {cnt, {FRAC_W{1'b0}}};
    fl     = LIM_W'({fade_length_r, {FRAC_W{1'b0}}});
    idx_s  = idx_r[LIM_W-1:0];
    i0_ext = LIM_CNT_W'(idx_r[FRAC_W +: ADDR_W]);
    i1_ext = i0_ext + 1'b1;
    cnt_m1 = cnt - 1'b1;
    near_sum        = {1'b0, idx_s} + {1'b0, fl};
    before_fade_end = IDX_W'(fl) > idx_r;
    env_sh = env_prod_r[ENV_PROD_W-1:FRAC_W];
  end

  always_comb begin
    s1    = $signed(ram_rdata);
    diff  = (SAMPLE_WIDTH+1)'(s1) - (SAMPLE_WIDTH+1)'(s0_r);
    dprod = VW'(diff) * VW'($signed({1'b0, frac_r}));
    rnd   = PE'(p_r) + (PE'(1) <<< (SH - 1));
    r_sh  = rnd >>> SH;
    if (r_sh > SAT_HI) begin
      audio_sat = AUDIO_W'(SAT_HI);
    end else if (r_sh < SAT_LO) begin
      audio_sat = AUDIO_W'(SAT_LO);
    end else begin
      audio_sat = r_sh[AUDIO_W-1:0];
    end
  end

  always_comb begin
    ld_addr_ext = 17'(in_address);
    ram_we      = cmd.load_wr && (ld_addr_ext < 17'(MEM_DEPTH));
    priority if (cmd.load_wr) begin
      ram_addr = ld_addr_ext[ADDR_W-1:0];
    end else if (cmd.idx) begin
      ram_addr = idx_r[FRAC_W +: ADDR_W];
    end else begin
      ram_addr = i1_r;
    end
  end

  assign mod_start = cmd.start_send || cmd.start_pos;
  assign mod_dvd   = cmd.start_send ? send : DIV_W'(bp_r);

  bgsp_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (scale_in(in_sample_value)),
    .rdata (ram_rdata)
  );

  bgsp_modu u_modu (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (cyc),
    .rem      (mod_rem),
    .done     (mod_done)
  );

  // configuration, position and control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= CNT_W'(14400);
      cycle_length_r <= POS_W'(96000);
      slot_start_r   <= '0;
      slot_length_r  <= POS_W'(19200);
      step_r         <= STEP_W'(65536);
      fade_length_r  <= CNT_W'(480);
      fade_gain_r    <= GAIN_W'(136);
      bp_r           <= '0;
      send_ok_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_SAMPLE_COUNT: sample_count_r <= cfg_wdata[CNT_W-1:0];
          CFG_CYCLE_LENGTH: cycle_length_r <= cfg_wdata[POS_W-1:0];
          CFG_SLOT_START:   slot_start_r   <= cfg_wdata[POS_W-1:0];
          CFG_SLOT_LENGTH:  slot_length_r  <= cfg_wdata[POS_W-1:0];
          CFG_STEP:         step_r         <= cfg_wdata[STEP_W-1:0];
          CFG_FADE_LENGTH:  fade_length_r  <= cfg_wdata[CNT_W-1:0];
          CFG_FADE_GAIN:    fade_gain_r    <= cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
        // cached wrapped window end depends on these three
        if (cfg_index == CFG_CYCLE_LENGTH || cfg_index == CFG_SLOT_START ||
            cfg_index == CFG_SLOT_LENGTH) begin
          send_ok_r <= 1'b0;
        end
      end
      if (cmd.store_send) begin
        send_ok_r <= 1'b1;
      end
      if (cmd.set_pos) begin
        bp_r <= in_position;
      end else if (cmd.store_pos) begin
        bp_r <= mod_rem[POS_W-1:0];
      end else if (cmd.render_chk) begin
        bp_r <= (pos_inc >= cyc) ? '0 : pos_inc[POS_W-1:0];
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload pipeline of one render item
  always_ff @(posedge clk) begin
    if (cmd.store_send) begin
      send_mod_r <= mod_rem;
    end
    if (cmd.render_chk) begin
      t_r      <= t2[POS_W-1:0];
      gate_r   <= inwin;
      silent_r <= !inwin || (t2 < 0);
    end
    if (cmd.mul) begin
      idx_r <= IDX_W'(t_r) * IDX_W'(step_r);
    end
    if (cmd.idx) begin
      over_r     <= idx_r >= IDX_W'(lim);
      i1_r       <= (i1_ext > cnt_m1) ? cnt_m1[ADDR_W-1:0] : i1_ext[ADDR_W-1:0];
      frac_r     <= idx_r[FRAC_W-1:0];
      env_a_r    <= before_fade_end ? idx_s : lim - idx_s;
      env_full_r <= !before_fade_end && !(near_sum > {1'b0, lim});
    end
    if (cmd.rd1) begin
      s0_r       <= $signed(ram_rdata);
      env_prod_r <= ENV_PROD_W'(env_a_r) * ENV_PROD_W'(fade_gain_r);
    end
    if (cmd.interp) begin
      v_r <= (VW'(s0_r) <<< FRAC_W) + dprod;
      if (env_full_r || env_sh > (ENV_PROD_W-FRAC_W)'(ENV_ONE)) begin
        env_r <= ENV_ONE;
      end else begin
        env_r <= env_sh[ENV_W-1:0];
      end
    end
    if (cmd.prod) begin
      p_r <= PW'(v_r) * PW'($signed({1'b0, env_r}));
    end
    if (cmd.out_load) begin
      out_audio_r <= (silent_r || over_r) ? '0 : audio_sat;
      out_gate_r  <= gate_r;
    end
  end

  assign stat.send_ok   = send_ok_r;
  assign stat.bp_ge_cyc = pos >= cyc;
  assign stat.mod_done  = mod_done;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_audio = out_audio_r;
  assign out_gate  = out_gate_r;

endmodule

// ===== rtl/bgsp_ctrl.sv =====
// Controller state machine: sequences load, set position and render items.
module bgsp_ctrl import bgsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  bgsp_mode_t in_mode,
  input  bgsp_stat_t stat,
  output bgsp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_MSEND = 4'd2;
  localparam logic [3:0] S_MPOS  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_IDX   = 4'd5;
  localparam logic [3:0] S_RD1   = 4'd6;
  localparam logic [3:0] S_INT   = 4'd7;
  localparam logic [3:0] S_PRD   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.load_wr = accept && (in_mode == MODE_LOAD);
        cmd.set_pos = accept && (in_mode == MODE_SETPOS);
        if (accept && in_mode == MODE_RENDER) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        // refresh the wrapped window end, then bring the position into the cycle
        priority if (!stat.send_ok) begin
          cmd.start_send = 1'b1;
          state_nxt      = S_MSEND;
        end else if (stat.bp_ge_cyc) begin
          cmd.start_pos = 1'b1;
          state_nxt     = S_MPOS;
        end else begin
          cmd.render_chk = 1'b1;
          state_nxt      = S_MUL;
        end
      end
      S_MSEND: begin
        if (stat.mod_done) begin
          cmd.store_send = 1'b1;
          state_nxt      = S_CHK;
        end
      end
      S_MPOS: begin
        if (stat.mod_done) begin
          cmd.store_pos = 1'b1;
          state_nxt     = S_CHK;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_IDX;
      end
      S_IDX: begin
        cmd.idx   = 1'b1;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd.rd1   = 1'b1;
        state_nxt = S_INT;
      end
      S_INT: begin
        cmd.interp = 1'b1;
        state_nxt  = S_PRD;
      end
      S_PRD: begin
        cmd.prod  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/beat_gated_sample_player_unit.sv =====
// Top level of the beat gated sample player.
// Plays a stored one-shot sample once per beat cycle inside a slot window, with
// linear interpolation between neighboring samples and a linear fade in and out.
// Load and set-position items produce no result. A render item passes through
// the controller's sequence: window test, index multiply, two reads of the
// single-port sample store, interpolation and envelope multiply. The bit-serial
// modulo unit adds a pass on the first render after reset or after a write of
// the cycle length, slot start or slot length, and one when the beat position
// lies at or past the cycle length (after a set position or a shorter cycle).
// One result waits in the output register; a render that finishes while it is
// still untaken holds until it leaves.
module beat_gated_sample_player_unit import bgsp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [47:0]           in_tdata,   // address[13:0], sample_value[29:14], position[47:30]
  input  logic [1:0]            in_tuser,   // mode[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // audio_out[15:0]
  output logic                  out_tuser,  // gate_active[0]
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  bgsp_cmd_t                 cmd;
  bgsp_stat_t                stat;
  bgsp_mode_t                in_mode;
  logic [IN_ADDR_W-1:0]      in_address;
  logic signed [15:0]        in_sample_value;
  logic [POS_W-1:0]          in_position;
  logic signed [AUDIO_W-1:0] audio_out;

  assign in_mode         = in_tuser;
  assign in_address      = in_tdata[13:0];
  assign in_sample_value = $signed(in_tdata[29:14]);
  assign in_position     = in_tdata[47:30];

  bgsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_mode  (in_mode),
    .stat     (stat),
    .cmd      (cmd)
  );

  bgsp_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_address      (in_address),
    .in_sample_value (in_sample_value),
    .in_position     (in_position),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_audio       (audio_out),
    .out_gate        (out_tuser)
  );

  assign out_tdata = audio_out;

endmodule

// ===== tb/tb_beat_gated_sample_player_unit.sv =====
// Testbench of the beat gated sample player: random load, set-position and render items.
import bgsp_pkg::*;

class sample_player_scoreboard;
  typedef struct packed {
    logic [AUDIO_W-1:0] audio;
    logic               gate;
  } tick_t;

  tick_t           tick_q[$];
  longint          store_mem[MEM_DEPTH];
  bit              written[MEM_DEPTH];
  longint unsigned beat_pos;
  longint unsigned reg_cnt, reg_cyc, reg_sstart, reg_slen, reg_step;
  longint unsigned reg_fade_len, reg_fade_gain;
  int              errors;

  function new();
    beat_pos      = 0;
    reg_cnt       = 14400;
    reg_cyc       = 96000;
    reg_sstart    = 0;
    reg_slen      = 19200;
    reg_step      = 65536;
    reg_fade_len  = 480;
    reg_fade_gain = 136;
    errors        = 0;
  endfunction

  function int pending();
    return tick_q.size();
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_SAMPLE_COUNT: reg_cnt = 64'(d[CNT_W-1:0]);
      CFG_CYCLE_LENGTH: reg_cyc = 64'(d[POS_W-1:0]);
      CFG_SLOT_START:   reg_sstart = 64'(d[POS_W-1:0]);
      CFG_SLOT_LENGTH:  reg_slen = 64'(d[POS_W-1:0]);
      CFG_STEP:         reg_step = 64'(d[STEP_W-1:0]);
      CFG_FADE_LENGTH:  reg_fade_len = 64'(d[CNT_W-1:0]);
      CFG_FADE_GAIN:    reg_fade_gain = 64'(d[GAIN_W-1:0]);
      default: ;
    endcase
  endfunction

  // Where the next render tick lands; fetch is set when it reads the store.
  function void locate(output logic gate, output bit fetch, output longint unsigned idx,
                       output longint unsigned lim, output longint unsigned i0,
                       output longint unsigned i1, output longint unsigned next_pos);
    longint unsigned cyc, pos, send, cnt;
    longint          slot_t;
    cyc      = (reg_cyc == 0) ? 64'd262144 : reg_cyc;
    pos      = beat_pos % cyc;
    next_pos = (pos + 1 >= cyc) ? 64'd0 : pos + 1;
    send     = reg_sstart + reg_slen;
    if (send <= cyc) begin
      gate = (pos >= reg_sstart) && (pos < send);
    end else begin
      gate = (pos >= reg_sstart) || (pos < send % cyc);
    end
    cnt   = (reg_cnt < MEM_DEPTH) ? reg_cnt : 64'(MEM_DEPTH);
    lim   = cnt << 16;
    fetch = 1'b0;
    idx   = 0;
    i0    = 0;
    i1    = 0;
    if (!gate) return;
    slot_t = longint'(pos) - longint'(reg_sstart);
    if (slot_t < 0) slot_t += longint'(cyc);
    // slot start far beyond a short cycle: gated but silent
    if (slot_t < 0) return;
    idx = 64'(slot_t) * reg_step;
    if (idx >= lim) return;
    fetch = 1'b1;
    i0    = idx >> 16;
    i1    = (i0 + 1 > cnt - 1) ? cnt - 1 : i0 + 1;
  endfunction

  // Store address the next render would read before it was ever loaded, or -1.
  function longint missing_read();
    logic            gate;
    bit              fetch;
    longint unsigned idx, lim, i0, i1, next_pos;
    locate(gate, fetch, idx, lim, i0, i1, next_pos);
    if (fetch && !written[i0[ADDR_W-1:0]]) return longint'(i0);
    if (fetch && !written[i1[ADDR_W-1:0]]) return longint'(i1);
    return -1;
  endfunction

  function void note_input(bgsp_mode_t mode, logic [IN_ADDR_W-1:0] addr,
                           logic signed [15:0] val, logic [POS_W-1:0] new_pos);
    bit              fetch;
    longint unsigned idx, lim, fl, env, i0, i1, next_pos;
    longint          s0, s1, frac, mix, prod, r;
    tick_t           tk;
    case (mode)
      MODE_LOAD: begin
        if (addr < MEM_DEPTH) begin
          store_mem[addr] = (longint'(val) <<< SCL_L) >>> SCL_R;
          written[addr]   = 1'b1;
        end
      end
      MODE_SETPOS: beat_pos = 64'(new_pos);
      MODE_RENDER: begin
        locate(tk.gate, fetch, idx, lim, i0, i1, next_pos);
        beat_pos = next_pos;
        tk.audio = '0;
        if (fetch) begin
          fl = reg_fade_len << 16;
          // fade-out test is signed: the fade may be longer than the sample
          if (idx < fl) begin
            env = (idx * reg_fade_gain) >> 16;
          end else if (longint'(idx) > longint'(lim) - longint'(fl)) begin
            env = ((lim - idx) * reg_fade_gain) >> 16;
          end else begin
            env = 64'd65536;
          end
          if (env > 64'd65536) env = 64'd65536;
          s0   = store_mem[i0[ADDR_W-1:0]];
          s1   = store_mem[i1[ADDR_W-1:0]];
          frac = longint'(idx & 64'hFFFF);
          mix  = s0 * 65536 + (s1 - s0) * frac;
          prod = mix * longint'(env);
          r    = (prod + (64'sd1 <<< (SH - 1))) >>> SH;
          if (r > 32767) r = 32767;
          else if (r < -32768) r = -32768;
          tk.audio = r[15:0];
        end
        tick_q.push_back(tk);
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic [AUDIO_W-1:0] audio, logic gate);
    tick_t tk;
    if (tick_q.size() == 0) begin
      $display("%0t: unexpected item: expected none, actual audio_out=%0d gate_active=%0b",
               $time, $signed(audio), gate);
      errors++;
      return;
    end
    tk = tick_q.pop_front();
    if (tk.audio !== audio) begin
      $display("%0t: audio_out mismatch: expected %0d, actual %0d",
               $time, $signed(tk.audio), $signed(audio));
      errors++;
    end
    if (tk.gate !== gate) begin
      $display("%0t: gate_active mismatch: expected %0b, actual %0b", $time, tk.gate, gate);
      errors++;
    end
  endfunction
endclass

module tb_beat_gated_sample_player_unit;
  localparam bgsp_mode_t MODE_SPARE  = 2'd3;
  localparam int         NUM_PHASES  = 20;
  localparam int         PHASE_ITEMS = 100;
  localparam int         HOLD_LEN    = 400;
  localparam int         SETTLE      = 64;
  localparam int         QUIET_LIMIT = 3000;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [47:0]           in_tdata   = '0;  // address[13:0], sample_value[29:14], position[47:30]
  logic [1:0]            in_tuser   = '0;  // mode[1:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;        // audio_out[15:0]
  logic                  out_tuser;        // gate_active[0]
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  int send_idle = 21;
  int recv_idle = 45;
  int hold_reqs = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  sample_player_scoreboard sb = new();

  beat_gated_sample_player_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random back-pressure plus requested long hold-offs
  always @(posedge clk) begin
    if (hold_reqs != hold_served) begin
      hold_served = hold_reqs;
      hold_left   = HOLD_LEN;
    end
    if (!rst_n || hold_left > 0) begin
      if (hold_left > 0) hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(bgsp_mode_t mode, logic [IN_ADDR_W-1:0] addr, logic [15:0] val,
                           logic [POS_W-1:0] new_pos);
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {new_pos, val, addr};
    do @(posedge clk); while (!in_tready);
    sb.note_input(mode, addr, val, new_pos);
  endtask

  // loads any store entry the tick would read before it was written
  task automatic render_tick();
    longint miss;
    miss = sb.missing_read();
    while (miss >= 0) begin
      send_item(MODE_LOAD, IN_ADDR_W'(miss), 16'($urandom), POS_W'($urandom));
      miss = sb.missing_read();
    end
    send_item(MODE_RENDER, IN_ADDR_W'($urandom), 16'($urandom), POS_W'($urandom));
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic program_regs(logic [31:0] cnt, logic [31:0] cyc, logic [31:0] sstart,
                              logic [31:0] slen, logic [31:0] stp, logic [31:0] fln,
                              logic [31:0] fg);
    cfg_write(CFG_SAMPLE_COUNT, cnt);
    cfg_write(CFG_CYCLE_LENGTH, cyc);
    cfg_write(CFG_SLOT_START, sstart);
    cfg_write(CFG_SLOT_LENGTH, slen);
    cfg_write(CFG_STEP, stp);
    cfg_write(CFG_FADE_LENGTH, fln);
    cfg_write(CFG_FADE_GAIN, fg);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // loads and position sets leave no result, so give the block time to finish
  task automatic settle_idle();
    wait_results();
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    logic [31:0]      cnt, cyc, sstart, slen, stp, fln, fg;
    int unsigned      cyc_eff, cnt_eff, sel;
    logic [POS_W-1:0] new_pos;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: extreme sample words, top address, spare mode, far position
    send_item(MODE_LOAD, 14'd0, 16'h7FFF, '0);
    send_item(MODE_LOAD, 14'd1, 16'h8000, '1);
    send_item(MODE_LOAD, 14'd2, 16'h0000, '0);
    send_item(MODE_LOAD, 14'h3FFF, 16'hFFFF, '1);
    send_item(MODE_SPARE, '1, '1, '1);
    send_item(MODE_SETPOS, '0, '0, 18'h3FFFF);
    render_tick();
    send_item(MODE_SETPOS, '1, '1, '0);
    repeat (3) render_tick();
    settle_idle();

    // count above the store size, fade-out on the last entry, then past the count
    program_regs(32'd32767, 32'd8, 32'd0, 32'd8, 32'h3FFF_8000, 32'd2, 32'd32768);
    send_item(MODE_SETPOS, '0, '0, '0);
    repeat (3) render_tick();
    settle_idle();

    // zero cycle length with the window wrapping past the cycle end
    program_regs(32'd2, 32'd0, 32'd262143, 32'd2, 32'hFFFF_FFFF, 32'd1, 32'd65535);
    send_item(MODE_SETPOS, '0, '0, 18'h3FFFF);
    repeat (2) render_tick();
    settle_idle();

    // slot start far past a short cycle: negative slot time
    program_regs(32'd4, 32'd100, 32'd300, 32'd50, 32'd65536, 32'd1, 32'd65535);
    send_item(MODE_SETPOS, '0, '0, 18'd10);
    render_tick();
    settle_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 7) begin
        send_idle <= 21;
        recv_idle <= 45;
      end else if (ph < 14) begin
        send_idle <= 45;
        recv_idle <= 21;
      end else begin
        send_idle <= 0;
        recv_idle <= 0;
      end
      if (ph == 0) begin
        cnt = 1; cyc = 1; sstart = 0; slen = 1; stp = 1; fln = 1; fg = 0;
      end else if (ph == 1) begin
        cnt = 32767; cyc = 262143; sstart = 262143; slen = 262143;
        stp = 32'hFFFF_FFFF; fln = 32767; fg = 65535;
      end else begin
        case ($urandom_range(9))
          0: cnt = 0;
          1: cnt = 1;
          2: cnt = 16384;
          3: cnt = 32767;
          default: cnt = $urandom_range(64, 2);
        endcase
        case ($urandom_range(9))
          0: cyc = 0;
          1: cyc = 1;
          2: cyc = 262143;
          default: cyc = $urandom_range(300, 2);
        endcase
        cyc_eff = (cyc == 0) ? 262144 : cyc;
        case ($urandom_range(9))
          0: sstart = 0;
          1: sstart = 262143;
          2: sstart = $urandom_range(262143);
          default: sstart = $urandom_range(cyc_eff - 1);
        endcase
        case ($urandom_range(9))
          0: slen = 0;
          1: slen = 262143;
          default: slen = $urandom_range(cyc_eff, 1);
        endcase
        case ($urandom_range(11))
          0: stp = 0;
          1: stp = 1;
          2: stp = 32'hFFFF_FFFF;
          3: stp = $urandom;
          default: stp = $urandom_range(32'h30000, 32'h800);
        endcase
        case ($urandom_range(9))
          0: fln = 0;
          1: fln = 16384;
          2: fln = 32767;
          default: fln = $urandom_range(32, 1);
        endcase
        case ($urandom_range(5))
          0: fg = 0;
          1: fg = 65535;
          2: fg = $urandom_range(65535);
          default: fg = (fln == 0 || 65536 / fln > 65535) ? 65535 : 65536 / fln;
        endcase
      end
      program_regs(cnt, cyc, sstart, slen, stp, fln, fg);
      if (ph == 4) hold_reqs <= hold_reqs + 1;
      cyc_eff = (cyc[POS_W-1:0] == 0) ? 262144 : cyc[POS_W-1:0];
      cnt_eff = (cnt[CNT_W-1:0] < MEM_DEPTH) ? cnt[CNT_W-1:0] : MEM_DEPTH;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 10 && n == PHASE_ITEMS / 2) wait_results();
        sel = $urandom_range(99);
        if (sel < 72) begin
          render_tick();
        end else if (sel < 84) begin
          send_item(MODE_LOAD,
                    ($urandom_range(3) == 0) ? IN_ADDR_W'($urandom) :
                    IN_ADDR_W'($urandom_range(cnt_eff > 0 ? cnt_eff - 1 : 0)),
                    16'($urandom), POS_W'($urandom));
        end else if (sel < 96) begin
          case ($urandom_range(4))
            0, 1: new_pos = POS_W'((sstart[POS_W-1:0] % cyc_eff) + $urandom_range(3));
            2, 3: new_pos = POS_W'($urandom_range(cyc_eff - 1));
            default: new_pos = POS_W'($urandom);
          endcase
          send_item(MODE_SETPOS, IN_ADDR_W'($urandom), 16'($urandom), new_pos);
        end else begin
          send_item(MODE_SPARE, IN_ADDR_W'($urandom), 16'($urandom), POS_W'($urandom));
        end
      end
      settle_idle();
    end

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/bgsp_pkg.sv
rtl/bgsp_ram.sv
rtl/bgsp_modu.sv
rtl/bgsp_dp.sv
rtl/bgsp_ctrl.sv
rtl/beat_gated_sample_player_unit.sv
tb/tb_beat_gated_sample_player_unit.sv
